// ===== src/pmbtc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and functions of the telemetry converter
package pmbtc_pkg;

   localparam int COEFF_W   = 52;
   localparam int NUM_COEFF = 4;
   localparam int CSR_IDX_W = 3;
   localparam int Q_W       = 63;
   localparam int DEN_W     = 39;
   localparam int T_W       = 45;
   localparam int NUM_CELLS = Q_W;

   localparam logic [COEFF_W-1:0] COEFF_RESET = 52'hFFFF000000001;

   localparam logic [1:0] KIND_VIN   = 2'd0;
   localparam logic [1:0] KIND_VOUT  = 2'd1;
   localparam logic [1:0] KIND_TEMP  = 2'd2;
   localparam logic [1:0] KIND_POWER = 2'd3;

   localparam logic [31:0] TEMP_MAX  = 32'd65535;
   localparam logic [31:0] VALUE_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [Q_W-1:0]   nq;
      logic [DEN_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic             neg;
      logic             temp;
      logic             zclip;
   } div_type;

   function automatic logic [26:0] pow10(input logic [3:0] k);
      logic [26:0] p;
      case (k)
         4'd0:    p = 27'd1;
         4'd1:    p = 27'd10;
         4'd2:    p = 27'd100;
         4'd3:    p = 27'd1000;
         4'd4:    p = 27'd10000;
         4'd5:    p = 27'd100000;
         4'd6:    p = 27'd1000000;
         4'd7:    p = 27'd10000000;
         4'd8:    p = 27'd100000000;
         default: p = 27'd1;
      endcase
      return p;
   endfunction

   function automatic logic signed [20:0] unit_scale(input logic [1:0] kind);
      logic signed [20:0] s;
      case (kind)
         KIND_VIN:   s = 21'sd1000000;
         KIND_VOUT:  s = 21'sd1000000;
         KIND_TEMP:  s = 21'sd1;
         KIND_POWER: s = 21'sd1000;
         default:    s = 21'sd1;
      endcase
      return s;
   endfunction

endpackage

// ===== src/pmbtc_ifs.sv =====
`timescale 1ns / 1ps
// channel interfaces: request, response and register write
interface pmbtc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] raw_word;
   logic        format_direct;
   modport source (output valid, kind, raw_word, format_direct, input ready);
   modport sink   (input valid, kind, raw_word, format_direct, output ready);
endinterface

interface pmbtc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic        clipped;
   modport source (output valid, value, clipped, input ready);
   modport sink   (input valid, value, clipped, output ready);
endinterface

interface pmbtc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [51:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/pmbtc_front.sv =====
`timescale 1ns / 1ps
// coefficient registers and numerator / divisor preparation stages
module pmbtc_front import pmbtc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pmbtc_req_if.sink   req_ch,
   pmbtc_csr_if.sink   csr_ch,
   output logic        out_valid,
   output div_type     out_data,
   input  logic        out_ready
);

   logic [COEFF_W-1:0] coeff_ff [NUM_COEFF];

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEFF; i++) coeff_ff[i] <= COEFF_RESET;
      end else if (csr_ch.valid && (csr_ch.index < CSR_IDX_W'(NUM_COEFF))) begin
         coeff_ff[csr_ch.index[1:0]] <= csr_ch.data;
      end
   end

   // stage a: fields and selected coefficient
   logic               a_valid_ff;
   logic [1:0]         a_kind_ff;
   logic [15:0]        a_raw_ff;
   logic               a_dir_ff;
   logic [COEFF_W-1:0] a_coeff_ff;
   // stage b: difference term and divisor
   logic                  b_valid_ff;
   logic [1:0]            b_kind_ff;
   logic signed [T_W-1:0] b_t_ff;
   logic [DEN_W-1:0]      b_den_ff;
   logic                  b_dneg_ff;
   logic                  b_zclip_ff;
   logic                  b_dir_ff;
   logic signed [4:0]     b_e_ff;
   // stage c: scaled numerator
   logic               c_valid_ff;
   logic [1:0]         c_kind_ff;
   logic signed [63:0] c_p_ff;
   logic [DEN_W-1:0]   c_den_ff;
   logic               c_dneg_ff;
   logic               c_zclip_ff;
   logic               c_dir_ff;
   logic signed [4:0]  c_e_ff;
   // stage d: cell chain entry
   logic    d_valid_ff;
   div_type d_data_ff;

   logic a_ready, b_ready, c_ready, d_ready;
   assign d_ready = !d_valid_ff || out_ready;
   assign c_ready = !c_valid_ff || d_ready;
   assign b_ready = !b_valid_ff || c_ready;
   assign a_ready = !a_valid_ff || b_ready;
   assign req_ch.ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= req_ch.valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
         if (d_ready) d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_kind_ff  <= req_ch.kind;
         a_raw_ff   <= req_ch.raw_word;
         a_dir_ff   <= req_ch.format_direct;
         a_coeff_ff <= coeff_ff[req_ch.kind];
      end
   end

   // stage b logic
   logic signed [15:0]    m_s, b_s;
   logic signed [3:0]     r_s;
   logic [15:0]           y;
   logic                  r_le0;
   logic [3:0]            r_abs;
   logic [26:0]           p10;
   logic signed [16:0]    mul_src;
   logic signed [T_W-1:0] prod1;
   logic [15:0]           m_abs;
   logic [DEN_W-1:0]      den_full;
   logic signed [T_W-1:0] b_t_in;
   logic [DEN_W-1:0]      b_den_in;

   always_comb begin
      m_s      = signed'(a_coeff_ff[15:0]);
      b_s      = signed'(a_coeff_ff[31:16]);
      r_s      = signed'(a_coeff_ff[35:32]);
      y        = a_raw_ff & a_coeff_ff[51:36];
      r_le0    = r_s[3] || (r_s == 4'sd0);
      r_abs    = r_s[3] ? 4'(-r_s) : 4'(r_s);
      p10      = pow10(r_abs);
      mul_src  = r_le0 ? signed'({1'b0, y}) : 17'(b_s);
      prod1    = T_W'(mul_src) * T_W'(signed'({1'b0, p10}));
      m_abs    = m_s[15] ? 16'(-m_s) : 16'(m_s);
      den_full = DEN_W'(m_abs) * DEN_W'(p10);
      if (a_dir_ff) begin
         b_t_in   = r_le0 ? (prod1 - T_W'(b_s)) : (T_W'(signed'({1'b0, y})) - prod1);
         b_den_in = r_le0 ? DEN_W'(m_abs) : den_full;
         if (m_s == 16'sd0) b_den_in = DEN_W'(1);
      end else begin
         b_t_in   = T_W'(signed'(a_raw_ff[10:0]));
         b_den_in = DEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready) begin
         b_kind_ff  <= a_kind_ff;
         b_t_ff     <= b_t_in;
         b_den_ff   <= b_den_in;
         b_dneg_ff  <= a_dir_ff && m_s[15];
         b_zclip_ff <= a_dir_ff && (m_s == 16'sd0);
         b_dir_ff   <= a_dir_ff;
         b_e_ff     <= signed'(a_raw_ff[15:11]);
      end
   end

   // stage c logic
   logic signed [63:0] prod2;
   assign prod2 = 64'(b_t_ff) * 64'(unit_scale(b_kind_ff));

   always_ff @(posedge clock) begin
      if (c_ready) begin
         c_kind_ff  <= b_kind_ff;
         c_p_ff     <= prod2;
         c_den_ff   <= b_den_ff;
         c_dneg_ff  <= b_dneg_ff;
         c_zclip_ff <= b_zclip_ff;
         c_dir_ff   <= b_dir_ff;
         c_e_ff     <= b_e_ff;
      end
   end

   // stage d logic
   logic signed [63:0] val;
   logic [DEN_W-1:0]   d_den;
   logic [4:0]         e_mag;
   div_type            d_data_in;

   always_comb begin
      e_mag = c_e_ff[4] ? 5'(-c_e_ff) : 5'(c_e_ff);
      val   = c_p_ff;
      d_den = c_den_ff;
      if (!c_dir_ff) begin
         if (c_e_ff[4]) begin
            d_den = DEN_W'(1) << e_mag;
         end else begin
            val = c_p_ff <<< e_mag;
         end
      end
      d_data_in.nq    = val[63] ? Q_W'(-val) : val[Q_W-1:0];
      d_data_in.rem   = '0;
      d_data_in.den   = d_den;
      d_data_in.neg   = val[63] ^ c_dneg_ff;
      d_data_in.temp  = (c_kind_ff == KIND_TEMP);
      d_data_in.zclip = c_zclip_ff;
   end

   always_ff @(posedge clock) begin
      if (d_ready) d_data_ff <= d_data_in;
   end

   assign out_valid = d_valid_ff;
   assign out_data  = d_data_ff;

endmodule

// ===== src/pmbtc_div_cell.sv =====
`timescale 1ns / 1ps
// one restoring division cell: one quotient bit per cell
module pmbtc_div_cell import pmbtc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  div_type in_data,
   output logic    in_ready,
   output logic    out_valid,
   output div_type out_data,
   input  logic    out_ready
);

   logic    valid_ff;
   div_type data_ff, data_in;
   logic [DEN_W:0] trial;
   logic           ge;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      trial   = {in_data.rem, in_data.nq[Q_W-1]};
      ge      = (trial >= {1'b0, in_data.den});
      data_in = in_data;
      data_in.rem = ge ? DEN_W'(trial - {1'b0, in_data.den}) : trial[DEN_W-1:0];
      data_in.nq  = {in_data.nq[Q_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/pmbtc_back.sv =====
`timescale 1ns / 1ps
// sign handling, clamping and response register
module pmbtc_back import pmbtc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  div_type     in_data,
   output logic        in_ready,
   pmbtc_rsp_if.source rsp_ch
);

   logic        valid_ff;
   logic [31:0] value_ff, value_in;
   logic        clip_ff, clip_in;
   logic [31:0] maxv;

   assign in_ready = !valid_ff || rsp_ch.ready;

   always_comb begin
      maxv = in_data.temp ? TEMP_MAX : VALUE_MAX;
      if (in_data.zclip) begin
         value_in = '0;
         clip_in  = 1'b1;
      end else if (in_data.neg) begin
         value_in = '0;
         clip_in  = (in_data.nq != '0);
      end else if (in_data.nq > Q_W'(maxv)) begin
         value_in = maxv;
         clip_in  = 1'b1;
      end else begin
         value_in = in_data.nq[31:0];
         clip_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         value_ff <= value_in;
         clip_ff  <= clip_in;
      end
   end

   assign rsp_ch.valid   = valid_ff;
   assign rsp_ch.value   = value_ff;
   assign rsp_ch.clipped = clip_ff;

endmodule

// ===== src/pmbus_telemetry_converter_unit.sv =====
`timescale 1ns / 1ps
// top level of the pmbus telemetry converter
//  channel  | direction | contents
//  req_ch   | in        | kind, raw_word, format_direct
//  rsp_ch   | out       | value, clipped
//  csr_ch   | in        | index, data (coefficient write, always ready)
// one transaction per cycle sustained while rsp_ch is ready; back-pressure stalls the pipeline
// the 63-cell division chain computes one quotient bit per cell
// synchronous reset clears valid flags and loads default coefficients
// each stage stalls only when its successor is full, so bubbles collapse
module pmbus_telemetry_converter_unit import pmbtc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pmbtc_req_if.sink   req_ch,
   pmbtc_rsp_if.source rsp_ch,
   pmbtc_csr_if.sink   csr_ch
);

   logic    cell_valid [NUM_CELLS+1];
   logic    cell_ready [NUM_CELLS+1];
   div_type cell_data  [NUM_CELLS+1];

   pmbtc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_ch    (csr_ch),
      .out_valid (cell_valid[0]),
      .out_data  (cell_data[0]),
      .out_ready (cell_ready[0])
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      pmbtc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[i]),
         .in_data   (cell_data[i]),
         .in_ready  (cell_ready[i]),
         .out_valid (cell_valid[i+1]),
         .out_data  (cell_data[i+1]),
         .out_ready (cell_ready[i+1])
      );
   end

   pmbtc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (cell_valid[NUM_CELLS]),
      .in_data  (cell_data[NUM_CELLS]),
      .in_ready (cell_ready[NUM_CELLS]),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== dv/pmbus_telemetry_converter_checker.sv =====
`timescale 1ns / 1ps
// scoreboard of the telemetry converter: predicts each conversion and checks responses
module pmbus_telemetry_converter_checker import pmbtc_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   pmbtc_req_if  req_ch,
   pmbtc_rsp_if  rsp_ch,
   pmbtc_csr_if  csr_ch,
   output int    fail_count,
   output int    pending
);

   typedef struct packed {
      logic [31:0] value;
      logic        clipped;
   } reading_type;

   logic [COEFF_W-1:0] coeff_regs [NUM_COEFF];
   reading_type        expected_readings [$];

   function automatic longint dec_pow(input int k);
      longint p;
      p = 1;
      for (int i = 0; i < k; i++) p = p * 10;
      return p;
   endfunction

   function automatic reading_type convert_word(input logic [1:0] kind,
                                                input logic [15:0] raw,
                                                input logic direct);
      reading_type        res;
      logic [COEFF_W-1:0] c;
      longint             scale, maxv, q, m, b, r, y, mant, e;
      logic               clip;
      c     = coeff_regs[kind];
      scale = (kind == KIND_TEMP) ? 1 : (kind == KIND_POWER) ? 1000 : 1000000;
      maxv  = (kind == KIND_TEMP) ? 65535 : 64'h0_FFFF_FFFF;
      q     = 0;
      clip  = 1'b0;
      if (direct) begin
         m = longint'($signed(c[15:0]));
         b = longint'($signed(c[31:16]));
         r = longint'($signed(c[35:32]));
         y = longint'({48'd0, raw & c[51:36]});
         if (m == 0) begin
            clip = 1'b1;
         end else if (r <= 0) begin
            q = ((y * dec_pow(int'(-r)) - b) * scale) / m;
         end else begin
            q = ((y - b * dec_pow(int'(r))) * scale) / (m * dec_pow(int'(r)));
         end
      end else begin
         mant = longint'($signed(raw[10:0]));
         e    = longint'($signed(raw[15:11]));
         if (e >= 0) q = mant * scale * (64'sd1 << e);
         else        q = (mant * scale) / (64'sd1 << (-e));
      end
      if (!clip) begin
         if (q < 0) begin
            q    = 0;
            clip = 1'b1;
         end else if (q > maxv) begin
            q    = maxv;
            clip = 1'b1;
         end
      end
      res.value   = q[31:0];
      res.clipped = clip;
      return res;
   endfunction

   always @(posedge clock) begin
      reading_type got, want;
      int          errs;
      errs = 0;
      if (reset) begin
         for (int i = 0; i < NUM_COEFF; i++) coeff_regs[i] <= COEFF_RESET;
         expected_readings.delete();
         fail_count <= 0;
         pending    <= 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready && csr_ch.index < NUM_COEFF)
            coeff_regs[csr_ch.index[1:0]] <= csr_ch.data;
         if (req_ch.valid && req_ch.ready)
            expected_readings.push_back(convert_word(req_ch.kind, req_ch.raw_word,
                                                     req_ch.format_direct));
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.value   = rsp_ch.value;
            got.clipped = rsp_ch.clipped;
            if (expected_readings.size() == 0) begin
               $error("unexpected response transaction value=%0d clipped=%0d",
                      got.value, got.clipped);
               errs++;
            end else begin
               want = expected_readings.pop_front();
               if (got.value !== want.value) begin
                  $error("value mismatch: expected %0d actual %0d", want.value, got.value);
                  errs++;
               end
               if (got.clipped !== want.clipped) begin
                  $error("clipped mismatch: expected %0d actual %0d",
                         want.clipped, got.clipped);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending    <= expected_readings.size();
      end
   end

endmodule

// ===== dv/pmbus_telemetry_converter_unit_tb.sv =====
`timescale 1ns / 1ps
// testbench top of the telemetry converter: stimulus, register set-up and verdict
module pmbus_telemetry_converter_unit_tb;
   import pmbtc_pkg::*;

   localparam logic [2:0] REG_VIN    = 3'd0;
   localparam logic [2:0] REG_VOUT   = 3'd1;
   localparam logic [2:0] REG_TEMP   = 3'd2;
   localparam logic [2:0] REG_POWER  = 3'd3;
   localparam logic [2:0] REG_UNUSED = 3'd4;
   localparam int         DRAIN      = 100;
   localparam int         CYCLE_CAP  = 600000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   idle_pct;
   int   stall_pct;
   int   cycles;

   pmbtc_req_if req_ch ();
   pmbtc_rsp_if rsp_ch ();
   pmbtc_csr_if csr_ch ();

   pmbus_telemetry_converter_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   pmbus_telemetry_converter_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else       rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_word(input logic [1:0] kind, input logic [15:0] raw,
                            input logic direct);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.kind          <= kind;
      req_ch.raw_word      <= raw;
      req_ch.format_direct <= direct;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_coeff(input logic [2:0] idx, input logic [COEFF_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [COEFF_W-1:0] random_coeff();
      logic [15:0] m, b, mask;
      logic [3:0]  r;
      m    = 16'($urandom);
      b    = 16'($urandom);
      r    = 4'($urandom);
      mask = ($urandom_range(3) == 0) ? 16'($urandom) : 16'hFFFF;
      case ($urandom_range(5))
         0: m = 16'd0;
         1: m = 16'($urandom_range(1, 20));
         2: b = 16'd0;
         3: r = 4'($urandom_range(0, 3));
         default: ;
      endcase
      return {mask, r, b, m};
   endfunction

   task automatic random_setup();
      for (int i = 0; i < NUM_COEFF; i++) write_coeff(3'(i), random_coeff());
   endtask

   task automatic random_burst(input int count);
      logic [15:0] raw;
      for (int i = 0; i < count; i++) begin
         raw = 16'($urandom);
         if ($urandom_range(3) == 0) raw[15:11] = 5'($urandom_range(0, 6));
         send_word(2'($urandom), raw, 1'($urandom));
      end
   endtask

   initial begin
      reset                = 1'b1;
      cycles               = 0;
      idle_pct             = 0;
      stall_pct            = 0;
      req_ch.valid         = 1'b0;
      req_ch.kind          = KIND_VIN;
      req_ch.raw_word      = 16'd0;
      req_ch.format_direct = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = REG_VIN;
      csr_ch.data          = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // linear11 extremes with reset coefficients
      send_word(KIND_VIN,   16'h7BFF, 1'b0);
      send_word(KIND_VOUT,  16'h8001, 1'b0);
      send_word(KIND_TEMP,  16'h87FF, 1'b0);
      send_word(KIND_TEMP,  16'h7800, 1'b0);
      send_word(KIND_POWER, 16'h03FF, 1'b0);
      send_word(KIND_POWER, 16'h0400, 1'b0);
      send_word(KIND_VIN,   16'h0000, 1'b0);
      send_word(KIND_VIN,   16'hFFFF, 1'b0);
      send_word(KIND_TEMP,  16'h0BFF, 1'b0);
      // direct with unit slope
      send_word(KIND_VIN,   16'hFFFF, 1'b1);
      send_word(KIND_TEMP,  16'hFFFF, 1'b1);
      send_word(KIND_POWER, 16'h0000, 1'b1);
      wait_idle();

      write_coeff(REG_VIN,    {16'hFFFF, 4'h8, 16'h8000, 16'h8000});
      write_coeff(REG_VOUT,   {16'hFFFF, 4'h7, 16'h7FFF, 16'h7FFF});
      write_coeff(REG_TEMP,   {16'h00FF, 4'h0, 16'h0000, 16'h0000});
      write_coeff(REG_POWER,  {16'hFFFF, 4'hF, 16'h0005, 16'hFFFF});
      write_coeff(REG_UNUSED, {COEFF_W{1'b1}});
      send_word(KIND_VIN,   16'hFFFF, 1'b1);
      send_word(KIND_VIN,   16'h0000, 1'b1);
      send_word(KIND_VOUT,  16'hFFFF, 1'b1);
      send_word(KIND_VOUT,  16'h0000, 1'b1);
      send_word(KIND_TEMP,  16'h1234, 1'b1);
      send_word(KIND_POWER, 16'h0001, 1'b1);
      send_word(KIND_POWER, 16'h8000, 1'b1);
      send_word(KIND_VIN,   16'h7C01, 1'b0);
      wait_idle();

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 37 : 88) : 0;
         stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 37 : 88) : 0;
         if (phase == 0) begin
            write_coeff(REG_VIN,    {COEFF_W{1'b0}});
            write_coeff(REG_VOUT,   {COEFF_W{1'b1}});
            write_coeff(REG_TEMP,   COEFF_RESET);
            write_coeff(REG_POWER,  random_coeff());
            write_coeff(REG_UNUSED, random_coeff());
         end else begin
            random_setup();
         end
         random_burst(130);
         if (phase == 1) wait_idle();
         random_burst(130);
         wait_idle();
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
